FILE: sv/sje_pkg.sv
// Shared types, constants and fixed-point helpers for the 3x3 Jacobi eigen solver.
`timescale 1ns / 1ps

package sje_pkg;

	localparam int DATA_WIDTH   = 32;
	localparam int FRAC_BITS    = 30;
	localparam int CORDIC_STEPS = 32;
	localparam int IO_WIDTH     = 32;
	localparam int IO_FRAC      = 30;

	localparam int IN_WIDTH  = 6 * IO_WIDTH;
	localparam int OUT_WIDTH = 8 * IO_WIDTH;

	localparam int CS_WIDTH  = FRAC_BITS + 2;
	localparam int STEP_W    = $clog2(CORDIC_STEPS);
	localparam int MEM_DEPTH = 18;
	localparam int ADDR_W    = $clog2(MEM_DEPTH);
	localparam int V_BASE    = 9;

	localparam int SWEEP_W    = 4;
	localparam int THR_W      = 20;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 20;

	localparam int IO_UP = (FRAC_BITS >= IO_FRAC) ? FRAC_BITS - IO_FRAC : 0;
	localparam int IO_DN = (FRAC_BITS < IO_FRAC) ? IO_FRAC - FRAC_BITS : 0;

	typedef logic signed [DATA_WIDTH-1:0] word_t;
	typedef logic signed [DATA_WIDTH:0]   diff_t;
	typedef logic signed [CS_WIDTH-1:0]   coef_t;
	typedef logic signed [63:0]           wide_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SWEEP_LIMIT = 2'd0,
		CFG_CONV_THR    = 2'd1,
		CFG_SKIP_THR    = 2'd2
	} cfg_idx_t;

	typedef struct packed {
		logic  start;
		diff_t vy;
		diff_t vx;
	} cordic_req_t;

	typedef struct packed {
		logic  start;
		word_t u;
		word_t w;
	} mac_req_t;

	localparam wide_t KINV_Q61 = 64'sd1400229935014726477;
	localparam wide_t W_MAX    = (64'sd1 <<< (DATA_WIDTH - 1)) - 64'sd1;
	localparam wide_t W_MIN    = -(64'sd1 <<< (DATA_WIDTH - 1));

	// Shift-subtract long division, evaluated only on constants.
	function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
		logic [64:0] rem;
		logic [63:0] quo;
		rem = '0;
		quo = '0;
		for (int b = 63; b >= 0; b--) begin
			rem = {rem[63:0], n[b]};
			if (rem >= {1'b0, d}) begin
				rem    = rem - {1'b0, d};
				quo[b] = 1'b1;
			end
		end
		return quo;
	endfunction

	// Integer power series of atan in Q60; step by shift or by divisor.
	function automatic wide_t atan_series(input logic [63:0] p_in, input logic [63:0] divisor,
		input int shift);
		logic [63:0] p;
		wide_t       sum;
		wide_t       t;
		p   = p_in;
		sum = '0;
		for (int k = 0; k < 64; k++) begin
			if (p != 0) begin
				t = $signed(udiv64(p, 64'(2 * k + 1)));
				if ((k & 1) != 0) sum = sum - t;
				else sum = sum + t;
				if (shift != 0) p = (shift < 64) ? (p >> shift) : '0;
				else p = udiv64(p, divisor);
			end
		end
		return sum;
	endfunction

	function automatic logic [CORDIC_STEPS*64-1:0] atan_table();
		logic [CORDIC_STEPS*64-1:0] tab;
		logic [63:0]                one;
		one = 64'd1 << 60;
		tab = '0;
		tab[63:0] = atan_series(one >> 1, 64'd4, 0) + atan_series(udiv64(one, 64'd3), 64'd9, 0);
		for (int i = 1; i < CORDIC_STEPS; i++)
			tab[i*64 +: 64] = atan_series(one >> i, 64'd1, 2 * i);
		return tab;
	endfunction

	localparam logic [CORDIC_STEPS*64-1:0] ATAN_TAB = atan_table();
	localparam wide_t PI_Q60 = $signed(ATAN_TAB[63:0]) <<< 2;

	function automatic word_t satw(input wide_t v);
		if (v > W_MAX) return W_MAX[DATA_WIDTH-1:0];
		if (v < W_MIN) return W_MIN[DATA_WIDTH-1:0];
		return v[DATA_WIDTH-1:0];
	endfunction

	localparam word_t ONE = satw(64'sd1 <<< FRAC_BITS);

	function automatic logic [DATA_WIDTH-1:0] mag_w(input word_t v);
		return v[DATA_WIDTH-1] ? DATA_WIDTH'(-v) : DATA_WIDTH'(v);
	endfunction

	// Round half toward +infinity, then arithmetic shift.
	function automatic wide_t rshr64(input wide_t v, input int s);
		if (s == 0) return v;
		return (v + (64'sd1 <<< (s - 1))) >>> s;
	endfunction

	function automatic word_t from_io(input logic [IO_WIDTH-1:0] raw);
		wide_t v;
		v = 64'($signed(raw));
		if (IO_UP > 0) v = v <<< IO_UP;
		else v = rshr64(v, IO_DN);
		return satw(v);
	endfunction

	function automatic logic [IO_WIDTH-1:0] to_io(input word_t w);
		wide_t v;
		v = 64'(w);
		if (IO_DN > 0) v = v <<< IO_DN;
		else v = rshr64(v, IO_UP);
		if (v > 64'sd2147483647) v = 64'sd2147483647;
		if (v < -64'sd2147483648) v = -64'sd2147483648;
		return v[IO_WIDTH-1:0];
	endfunction

endpackage

FILE: sv/sje_cordic.sv
// Shared CORDIC unit: vectoring for the half angle, then rotation for cos and sin.
`timescale 1ns / 1ps

module sje_cordic (
	input  logic                clk,
	input  logic                arst_n,
	input  sje_pkg::cordic_req_t req,
	output sje_pkg::coef_t      cos_q,
	output sje_pkg::coef_t      sin_q,
	output logic                done_q
);

	localparam int CS_SHIFT = 61 - sje_pkg::FRAC_BITS;
	localparam sje_pkg::wide_t CS_RND = 64'sd1 <<< (CS_SHIFT - 1);

	typedef enum logic [2:0] {
		C_IDLE,
		C_PREP,
		C_NORM,
		C_VEC,
		C_HALF,
		C_ROT,
		C_FIN
	} cst_t;

	cst_t                            state_q;
	sje_pkg::wide_t                  x_q, y_q, z_q;
	logic [sje_pkg::STEP_W-1:0]      step_q;

	sje_pkg::wide_t tab_i, xs, ys, nx, ny, nz, ay;
	logic           dir, last, fits, big8;

	always_comb begin
		tab_i = $signed(sje_pkg::ATAN_TAB[step_q*64 +: 64]);
		xs    = x_q >>> step_q;
		ys    = y_q >>> step_q;
		// rotate counterclockwise on a nonnegative angle, or on a negative y
		dir   = (state_q == C_ROT) ? !z_q[63] : y_q[63];
		nx    = dir ? x_q - ys : x_q + ys;
		ny    = dir ? y_q + xs : y_q - xs;
		nz    = dir ? z_q - tab_i : z_q + tab_i;
		ay    = y_q[63] ? -y_q : y_q;
		last  = (step_q == sje_pkg::STEP_W'(sje_pkg::CORDIC_STEPS - 1));
		fits  = (x_q[63:59] == '0) && (ay[63:59] == '0);
		big8  = (x_q[63:51] == '0) && (ay[63:51] == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				C_IDLE: begin
					if (req.start) begin
						x_q     <= 64'($signed(req.vx));
						y_q     <= 64'($signed(req.vy));
						state_q <= C_PREP;
					end
				end
				C_PREP: begin
					if (x_q == '0 && y_q == '0) begin
						x_q     <= sje_pkg::KINV_Q61;
						y_q     <= '0;
						z_q     <= '0;
						step_q  <= '0;
						state_q <= C_ROT;
					end else begin
						if (x_q[63]) begin
							x_q <= -x_q;
							y_q <= -y_q;
							z_q <= y_q[63] ? -sje_pkg::PI_Q60 : sje_pkg::PI_Q60;
						end else begin
							z_q <= '0;
						end
						state_q <= C_NORM;
					end
				end
				C_NORM: begin
					// bring the larger magnitude into [2^59, 2^60)
					if (big8) begin
						x_q <= x_q <<< 8;
						y_q <= y_q <<< 8;
					end else if (fits) begin
						x_q <= x_q <<< 1;
						y_q <= y_q <<< 1;
					end else begin
						step_q  <= '0;
						state_q <= C_VEC;
					end
				end
				C_VEC: begin
					x_q <= nx;
					y_q <= ny;
					z_q <= nz;
					if (last) state_q <= C_HALF;
					else step_q <= step_q + 1'b1;
				end
				C_HALF: begin
					z_q     <= z_q >>> 1;
					x_q     <= sje_pkg::KINV_Q61;
					y_q     <= '0;
					step_q  <= '0;
					state_q <= C_ROT;
				end
				C_ROT: begin
					x_q <= nx;
					y_q <= ny;
					z_q <= nz;
					if (last) state_q <= C_FIN;
					else step_q <= step_q + 1'b1;
				end
				C_FIN: begin
					cos_q   <= sje_pkg::CS_WIDTH'((x_q + CS_RND) >>> CS_SHIFT);
					sin_q   <= sje_pkg::CS_WIDTH'((y_q + CS_RND) >>> CS_SHIFT);
					done_q  <= 1'b1;
					state_q <= C_IDLE;
				end
				default: state_q <= C_IDLE;
			endcase
		end
	end

endmodule

FILE: sv/sje_mac.sv
// Shared multiplier: forms c*u - s*w and s*u + c*w with rounding and saturation.
`timescale 1ns / 1ps

module sje_mac (
	input  logic              clk,
	input  logic              arst_n,
	input  sje_pkg::mac_req_t req,
	input  sje_pkg::coef_t    cos_i,
	input  sje_pkg::coef_t    sin_i,
	output sje_pkg::word_t    res1_q,
	output sje_pkg::word_t    res2_q,
	output logic              done_q
);

	localparam int PROD_W = sje_pkg::CS_WIDTH + sje_pkg::DATA_WIDTH;
	localparam int RND_W  = sje_pkg::DATA_WIDTH + 1;
	localparam int ACC_W  = sje_pkg::DATA_WIDTH + 2;
	localparam logic signed [PROD_W-1:0] HALF = PROD_W'(1) <<< (sje_pkg::FRAC_BITS - 1);

	logic                        busy_q;
	logic [1:0]                  iss_q;
	sje_pkg::word_t              u_q, w_q;
	logic signed [PROD_W-1:0]    prod_s1;
	logic                        v_s1;
	logic [1:0]                  idx_s1;
	logic signed [RND_W-1:0]     rnd_s2;
	logic                        v_s2;
	logic [1:0]                  idx_s2;
	logic signed [RND_W-1:0]     acc_q;

	sje_pkg::coef_t              coef;
	sje_pkg::word_t              opnd;
	logic signed [PROD_W-1:0]    rsum;
	logic signed [ACC_W-1:0]     sum;

	always_comb begin
		case (iss_q)
			2'd0: begin coef = cos_i;  opnd = u_q; end
			2'd1: begin coef = -sin_i; opnd = w_q; end
			2'd2: begin coef = sin_i;  opnd = u_q; end
			default: begin coef = cos_i; opnd = w_q; end
		endcase
		// ties away from zero: bias down by one on negative products
		rsum = prod_s1 + HALF - PROD_W'(prod_s1[PROD_W-1]);
		sum  = ACC_W'(acc_q) + ACC_W'(rnd_s2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			iss_q  <= '0;
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			v_s1   <= 1'b0;
			if (req.start) begin
				u_q    <= req.u;
				w_q    <= req.w;
				busy_q <= 1'b1;
				iss_q  <= '0;
			end else if (busy_q) begin
				prod_s1 <= PROD_W'(coef) * PROD_W'(opnd);
				v_s1    <= 1'b1;
				idx_s1  <= iss_q;
				iss_q   <= iss_q + 1'b1;
				if (iss_q == 2'd3) busy_q <= 1'b0;
			end
			v_s2   <= v_s1;
			idx_s2 <= idx_s1;
			rnd_s2 <= RND_W'(rsum >>> sje_pkg::FRAC_BITS);
			if (v_s2) begin
				case (idx_s2)
					2'd1: res1_q <= sje_pkg::satw(64'(sum));
					2'd3: begin
						res2_q <= sje_pkg::satw(64'(sum));
						done_q <= 1'b1;
					end
					default: acc_q <= rnd_s2;
				endcase
			end
		end
	end

endmodule

FILE: sv/symmetric_3x3_jacobi_eigen.sv
// Top level: cyclic Jacobi eigen solver for symmetric 3x3 matrices, top two eigenpairs.
`timescale 1ns / 1ps

// Channel   Direction  Handshake                     Payload
// s_axis    in         s_axis_tvalid/s_axis_tready   six matrix entries, Q1.30
// m_axis    out        m_axis_tvalid/m_axis_tready   two eigenvalues, two eigenvectors
// cfg       in         cfg_wr_en (no wait)           sweep limit and two thresholds
//
// One matrix at a time; the time per matrix grows with the number of sweeps run and
// the number of pairs rotated in each, and varies with the CORDIC normalization shifts.
// The shared CORDIC (two runs of CORDIC_STEPS iterations per rotation) and the
// single multiplier (four products per element pair, nine pairs) bound that time.
// Reset clears control and restores the register defaults; the matrix store needs
// no clearing since every item writes it before reading. A stalled output holds in
// its register while the next matrix is taken in and worked on.

module symmetric_3x3_jacobi_eigen (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	// m_xx, m_xy, m_xz, m_yy, m_yz, m_zz
	input  logic [sje_pkg::IN_WIDTH-1:0]    s_axis_tdata,
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// lambda_major, lambda_minor, major_vec_x/y/z, minor_vec_x/y/z
	output logic [sje_pkg::OUT_WIDTH-1:0]   m_axis_tdata,
	input  logic                            cfg_wr_en,
	input  logic [sje_pkg::CFG_IDX_W-1:0]   cfg_addr,
	input  logic [sje_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

	localparam int AW = sje_pkg::ADDR_W;
	localparam int W  = sje_pkg::DATA_WIDTH;

	// working matrix entries, row-major; eigenvectors follow at V_BASE
	localparam logic [AW-1:0] AD_00 = AW'(0);
	localparam logic [AW-1:0] AD_01 = AW'(1);
	localparam logic [AW-1:0] AD_02 = AW'(2);
	localparam logic [AW-1:0] AD_10 = AW'(3);
	localparam logic [AW-1:0] AD_11 = AW'(4);
	localparam logic [AW-1:0] AD_12 = AW'(5);
	localparam logic [AW-1:0] AD_20 = AW'(6);
	localparam logic [AW-1:0] AD_21 = AW'(7);
	localparam logic [AW-1:0] AD_22 = AW'(8);
	localparam logic [AW-1:0] AD_V  = AW'(sje_pkg::V_BASE);

	typedef enum logic [4:0] {
		S_IDLE, S_LOAD, S_SW_TOP, S_CONV1, S_CONV2, S_CONV3,
		S_PR1, S_PR2, S_PR3, S_CORD, S_ROT_RD, S_ROT_LD, S_MAC, S_WR1, S_WR2,
		S_SORT1, S_SORT2, S_SORT3, S_VEC1, S_VEC2, S_VEC3, S_VEC4, S_DONE
	} state_t;

	typedef enum logic [1:0] {
		P_COL,
		P_ROW,
		P_VEC
	} pass_t;

	// configuration
	logic [sje_pkg::SWEEP_W-1:0] sweep_limit_q;
	logic [sje_pkg::THR_W-1:0]   conv_thr_q;
	logic [sje_pkg::THR_W-1:0]   skip_thr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_limit_q <= sje_pkg::SWEEP_W'(10);
			conv_thr_q    <= sje_pkg::THR_W'(1);
			skip_thr_q    <= sje_pkg::THR_W'(1);
		end else if (cfg_wr_en) begin
			case (sje_pkg::cfg_idx_t'(cfg_addr))
				sje_pkg::CFG_SWEEP_LIMIT: sweep_limit_q <= cfg_wdata[sje_pkg::SWEEP_W-1:0];
				sje_pkg::CFG_CONV_THR:    conv_thr_q    <= cfg_wdata[sje_pkg::THR_W-1:0];
				sje_pkg::CFG_SKIP_THR:    skip_thr_q    <= cfg_wdata[sje_pkg::THR_W-1:0];
				default: ;
			endcase
		end
	end

	// sequencer state
	state_t                      state_q;
	sje_pkg::word_t              in_q [6];
	logic [AW-1:0]               ld_q;
	logic [sje_pkg::SWEEP_W-1:0] sw_q;
	logic [1:0]                  pi_q;
	pass_t                       pass_q;
	logic [1:0]                  k_q;
	logic [W:0]                  part_q;
	sje_pkg::word_t              apq_q, app_q, d0_q, d4_q;
	logic [1:0]                  ord0_q, ord1_q;
	logic [sje_pkg::IO_WIDTH-1:0] lam_maj_q, lam_min_q;
	logic [sje_pkg::IO_WIDTH-1:0] maj_x_q, maj_y_q, maj_z_q, min_x_q, min_y_q, min_z_q;
	logic                        m_tvalid_q;
	logic [sje_pkg::OUT_WIDTH-1:0] m_tdata_q;

	// matrix and eigenvector store
	sje_pkg::word_t mem [sje_pkg::MEM_DEPTH];
	sje_pkg::word_t rd_a_q, rd_b_q;
	logic [AW-1:0]  ra, rb, wa;
	logic           we;
	sje_pkg::word_t wd;

	// shared units
	sje_pkg::cordic_req_t cord_req;
	sje_pkg::coef_t       cos_v, sin_v;
	logic                 cord_done;
	sje_pkg::mac_req_t    mac_req;
	sje_pkg::word_t       res1, res2;
	logic                 mac_done;

	sje_cordic u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (cord_req),
		.cos_q  (cos_v),
		.sin_q  (sin_v),
		.done_q (cord_done)
	);

	sje_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mac_req),
		.cos_i  (cos_v),
		.sin_i  (sin_v),
		.res1_q (res1),
		.res2_q (res2),
		.done_q (mac_done)
	);

	// pair indices and element addresses
	logic [AW-1:0]  p_a, q_a, k_a, p3, q3, k3, u_addr, w_addr;
	logic           skip;
	logic [W+1:0]   conv_sum;
	sje_pkg::word_t va, vb, vc, tv;
	logic [1:0]     oa, ob, oc, to;

	always_comb begin
		p_a = (pi_q == 2'd2) ? AW'(1) : AW'(0);
		q_a = (pi_q == 2'd0) ? AW'(1) : AW'(2);
		k_a = AW'(k_q);
		p3  = (p_a << 1) + p_a;
		q3  = (q_a << 1) + q_a;
		k3  = (k_a << 1) + k_a;
		case (pass_q)
			P_COL: begin u_addr = k3 + p_a; w_addr = k3 + q_a; end
			P_ROW: begin u_addr = p3 + k_a; w_addr = q3 + k_a; end
			default: begin u_addr = AD_V + k3 + p_a; w_addr = AD_V + k3 + q_a; end
		endcase

		skip     = sje_pkg::mag_w(apq_q) < W'(skip_thr_q);
		conv_sum = (W + 2)'(part_q) + (W + 2)'(sje_pkg::mag_w(rd_a_q));

		// descending order, swap only on strict greater
		to = 2'd0; tv = '0;
		oa = 2'd0; va = d0_q;
		ob = 2'd1; vb = d4_q;
		oc = 2'd2; vc = rd_a_q;
		if (vb > va) begin to = oa; oa = ob; ob = to; tv = va; va = vb; vb = tv; end
		if (vc > va) begin to = oa; oa = oc; oc = to; tv = va; va = vc; vc = tv; end
		if (vc > vb) begin to = ob; ob = oc; oc = to; tv = vb; vb = vc; vc = tv; end

		ra = '0;
		rb = '0;
		case (state_q)
			S_CONV1:  begin ra = AD_01; rb = AD_02; end
			S_CONV2:  ra = AD_12;
			S_PR1:    begin ra = p3 + q_a; rb = p3 + p_a; end
			S_PR2:    ra = q3 + q_a;
			S_ROT_RD: begin ra = u_addr; rb = w_addr; end
			S_SORT1:  begin ra = AD_00; rb = AD_11; end
			S_SORT2:  ra = AD_22;
			S_VEC1:   begin ra = AD_V + AW'(ord0_q); rb = AD_V + AW'(ord1_q); end
			S_VEC2:   begin ra = AD_V + AD_10 + AW'(ord0_q); rb = AD_V + AD_10 + AW'(ord1_q); end
			S_VEC3:   begin ra = AD_V + AD_20 + AW'(ord0_q); rb = AD_V + AD_20 + AW'(ord1_q); end
			default: ;
		endcase

		we = 1'b0;
		wa = ld_q;
		wd = '0;
		case (state_q)
			S_LOAD: begin
				we = 1'b1;
				case (ld_q)
					AD_00: wd = in_q[0];
					AD_01, AD_10: wd = in_q[1];
					AD_02, AD_20: wd = in_q[2];
					AD_11: wd = in_q[3];
					AD_12, AD_21: wd = in_q[4];
					AD_22: wd = in_q[5];
					default: wd = (ld_q == AD_V || ld_q == AD_V + AD_11 || ld_q == AD_V + AD_22)
						? sje_pkg::ONE : '0;
				endcase
			end
			S_WR1: begin we = 1'b1; wa = u_addr; wd = res1; end
			S_WR2: begin we = 1'b1; wa = w_addr; wd = res2; end
			default: ;
		endcase

		cord_req.start = (state_q == S_PR3) && !skip;
		cord_req.vy    = {apq_q, 1'b0};
		cord_req.vx    = (W + 1)'(rd_a_q) - (W + 1)'(app_q);

		mac_req.start = (state_q == S_ROT_LD);
		mac_req.u     = rd_a_q;
		mac_req.w     = rd_b_q;
	end

	always_ff @(posedge clk) begin
		if (we) mem[wa] <= wd;
		rd_a_q <= mem[ra];
		rd_b_q <= mem[rb];
	end

	assign s_axis_tready = (state_q == S_IDLE);
	assign m_axis_tvalid = m_tvalid_q;
	assign m_axis_tdata  = m_tdata_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			m_tvalid_q <= 1'b0;
			ld_q       <= '0;
			sw_q       <= '0;
			pi_q       <= '0;
			pass_q     <= P_COL;
			k_q        <= '0;
		end else begin
			// drop the result once the sink takes it
			if (m_tvalid_q && m_axis_tready) m_tvalid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (s_axis_tvalid) begin
						for (int i = 0; i < 6; i++)
							in_q[i] <= sje_pkg::from_io(s_axis_tdata[i*sje_pkg::IO_WIDTH +:
								sje_pkg::IO_WIDTH]);
						ld_q    <= '0;
						state_q <= S_LOAD;
					end
				end
				S_LOAD: begin
					if (ld_q == AW'(sje_pkg::MEM_DEPTH - 1)) begin
						sw_q    <= '0;
						state_q <= S_SW_TOP;
					end else begin
						ld_q <= ld_q + 1'b1;
					end
				end
				S_SW_TOP: state_q <= (sw_q >= sweep_limit_q) ? S_SORT1 : S_CONV1;
				S_CONV1:  state_q <= S_CONV2;
				S_CONV2: begin
					part_q  <= (W + 1)'(sje_pkg::mag_w(rd_a_q)) + (W + 1)'(sje_pkg::mag_w(rd_b_q));
					state_q <= S_CONV3;
				end
				S_CONV3: begin
					if (conv_sum < (W + 2)'(conv_thr_q)) begin
						state_q <= S_SORT1;
					end else begin
						pi_q    <= '0;
						state_q <= S_PR1;
					end
				end
				S_PR1: state_q <= S_PR2;
				S_PR2: begin
					apq_q   <= rd_a_q;
					app_q   <= rd_b_q;
					state_q <= S_PR3;
				end
				S_PR3: begin
					if (!skip) begin
						state_q <= S_CORD;
					end else if (pi_q == 2'd2) begin
						sw_q    <= sw_q + 1'b1;
						state_q <= S_SW_TOP;
					end else begin
						pi_q    <= pi_q + 1'b1;
						state_q <= S_PR1;
					end
				end
				S_CORD: begin
					if (cord_done) begin
						pass_q  <= P_COL;
						k_q     <= '0;
						state_q <= S_ROT_RD;
					end
				end
				S_ROT_RD: state_q <= S_ROT_LD;
				S_ROT_LD: state_q <= S_MAC;
				S_MAC:    if (mac_done) state_q <= S_WR1;
				S_WR1:    state_q <= S_WR2;
				S_WR2: begin
					// advance element, then pass, then pair
					if (k_q != 2'd2) begin
						k_q     <= k_q + 1'b1;
						state_q <= S_ROT_RD;
					end else begin
						k_q <= '0;
						case (pass_q)
							P_COL: begin pass_q <= P_ROW; state_q <= S_ROT_RD; end
							P_ROW: begin pass_q <= P_VEC; state_q <= S_ROT_RD; end
							default: begin
								if (pi_q == 2'd2) begin
									sw_q    <= sw_q + 1'b1;
									state_q <= S_SW_TOP;
								end else begin
									pi_q    <= pi_q + 1'b1;
									state_q <= S_PR1;
								end
							end
						endcase
					end
				end
				S_SORT1: state_q <= S_SORT2;
				S_SORT2: begin
					d0_q    <= rd_a_q;
					d4_q    <= rd_b_q;
					state_q <= S_SORT3;
				end
				S_SORT3: begin
					ord0_q    <= oa;
					ord1_q    <= ob;
					lam_maj_q <= sje_pkg::to_io(va);
					lam_min_q <= sje_pkg::to_io(vb);
					state_q   <= S_VEC1;
				end
				S_VEC1: state_q <= S_VEC2;
				S_VEC2: begin
					maj_x_q <= sje_pkg::to_io(rd_a_q);
					min_x_q <= sje_pkg::to_io(rd_b_q);
					state_q <= S_VEC3;
				end
				S_VEC3: begin
					maj_y_q <= sje_pkg::to_io(rd_a_q);
					min_y_q <= sje_pkg::to_io(rd_b_q);
					state_q <= S_VEC4;
				end
				S_VEC4: begin
					maj_z_q <= sje_pkg::to_io(rd_a_q);
					min_z_q <= sje_pkg::to_io(rd_b_q);
					state_q <= S_DONE;
				end
				S_DONE: begin
					// hold until the output register is free
					if (!m_tvalid_q || m_axis_tready) begin
						m_tdata_q  <= {min_z_q, min_y_q, min_x_q, maj_z_q, maj_y_q, maj_x_q,
							lam_min_q, lam_maj_q};
						m_tvalid_q <= 1'b1;
						state_q    <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

FILE: tb/sv/symmetric_3x3_jacobi_eigen_test.sv
// Self-checking testbench for the 3x3 symmetric Jacobi eigen solver.
`timescale 1ns / 1ps

module symmetric_3x3_jacobi_eigen_test;

	localparam int CLK_HALF    = 1;
	localparam int IDLE_PCT    = 36;
	localparam int HOLD_CYCLES = 3000;
	// Slowest matrix runs 15 sweeps, three rotations each; allow for the long receiver
	// hold-off on top of that, several times over.
	localparam int STALL_LIMIT = 60000;
	localparam int RANDOM_ITEMS = 1150;
	localparam longint KINV = 64'sd1400229935014726477;

	logic                            clk;
	logic                            arst_n;
	logic                            s_axis_tvalid;
	logic                            s_axis_tready;
	logic [sje_pkg::IN_WIDTH-1:0]    s_axis_tdata;
	logic                            m_axis_tvalid;
	logic                            m_axis_tready;
	logic [sje_pkg::OUT_WIDTH-1:0]   m_axis_tdata;
	logic                            cfg_wr_en;
	logic [sje_pkg::CFG_IDX_W-1:0]   cfg_addr;
	logic [sje_pkg::CFG_DATA_W-1:0]  cfg_wdata;

	symmetric_3x3_jacobi_eigen i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),   // m_xx, m_xy, m_xz, m_yy, m_yz, m_zz
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),   // lambda_major, lambda_minor, major_vec_xyz, minor_vec_xyz
		.cfg_wr_en     (cfg_wr_en),
		.cfg_addr      (cfg_addr),
		.cfg_wdata     (cfg_wdata)
	);

	// Predictor copy of the configuration registers
	int unsigned sweeps_max;
	longint unsigned conv_limit;
	longint unsigned skip_limit;

	longint atan_q60[sje_pkg::CORDIC_STEPS];
	longint pi_q60;

	logic [sje_pkg::OUT_WIDTH-1:0] eigen_queue[$];
	int    fail_count;
	int    matrices_sent;
	int    results_seen;
	int    cfg_writes;
	bit    calm;          // no idling on either side while set
	int    hold_req_id;   // bump to ask the receiver for one long hold-off
	int    stall_cycles;

	string field_name[8] = '{"lambda_major", "lambda_minor", "major_vec_x", "major_vec_y",
		"major_vec_z", "minor_vec_x", "minor_vec_y", "minor_vec_z"};

	// ---------------------------------------------------------------- predictor

	function automatic longint atan_sum(logic [63:0] p, logic [63:0] div, int sh);
		longint acc;
		longint term;
		longint k;
		acc = 0;
		k = 0;
		while (p != 0) begin
			term = longint'(p / (2 * k + 1));
			acc = (k & 1) ? acc - term : acc + term;
			if (sh != 0) p = (sh < 64) ? p >> sh : '0;
			else p = p / div;
			k++;
		end
		return acc;
	endfunction

	function automatic longint sat_word(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	// Exact product, rounded to FRAC_BITS with ties away from zero
	function automatic longint scaled_prod(longint a, longint b);
		logic [127:0] p;
		logic [63:0]  ua;
		logic [63:0]  ub;
		bit           neg;
		neg = (a < 0) != (b < 0);
		ua = (a < 0) ? -a : a;
		ub = (b < 0) ? -b : b;
		p = {64'd0, ua} * {64'd0, ub};
		p = (p + (128'd1 << (sje_pkg::FRAC_BITS - 1))) >> sje_pkg::FRAC_BITS;
		if (p > 128'h7FFF_FFFF_FFFF_FFFF) return neg ? -64'sh7FFF_FFFF_FFFF_FFFF : 64'sh7FFF_FFFF_FFFF_FFFF;
		return neg ? -longint'(p[63:0]) : longint'(p[63:0]);
	endfunction

	function automatic longint rotate_pair(longint c1, longint u, longint c2, longint w);
		return sat_word(scaled_prod(c1, u) + scaled_prod(c2, w));
	endfunction

	function automatic longint abs_u(longint v);
		return (v < 0) ? -v : v;
	endfunction

	// Half of atan2(y, x) in Q60 via vectoring CORDIC
	function automatic longint half_theta(longint y, longint x);
		longint z;
		longint nx;
		longint ny;
		longint unsigned m;
		int s;
		z = 0;
		s = 0;
		if (x == 0 && y == 0) return 0;
		if (x < 0) begin
			z = (y >= 0) ? pi_q60 : -pi_q60;
			x = -x;
			y = -y;
		end
		m = (abs_u(x) > abs_u(y)) ? abs_u(x) : abs_u(y);
		while (m < (64'd1 << 59)) begin
			m = m << 1;
			s++;
		end
		x = x <<< s;
		y = y <<< s;
		for (int i = 0; i < sje_pkg::CORDIC_STEPS; i++) begin
			if (y >= 0) begin
				nx = x + (y >>> i); ny = y - (x >>> i); z += atan_q60[i];
			end else begin
				nx = x - (y >>> i); ny = y + (x >>> i); z -= atan_q60[i];
			end
			x = nx;
			y = ny;
		end
		return z >>> 1;
	endfunction

	function automatic void cos_sin_of(input longint th, output longint c, output longint s);
		longint x;
		longint y;
		longint nx;
		longint ny;
		x = KINV;
		y = 0;
		for (int i = 0; i < sje_pkg::CORDIC_STEPS; i++) begin
			if (th >= 0) begin
				nx = x - (y >>> i); ny = y + (x >>> i); th -= atan_q60[i];
			end else begin
				nx = x + (y >>> i); ny = y - (x >>> i); th += atan_q60[i];
			end
			x = nx;
			y = ny;
		end
		c = (x + (64'sd1 <<< (60 - sje_pkg::FRAC_BITS))) >>> (61 - sje_pkg::FRAC_BITS);
		s = (y + (64'sd1 <<< (60 - sje_pkg::FRAC_BITS))) >>> (61 - sje_pkg::FRAC_BITS);
	endfunction

	// I/O and internal formats coincide here (Q1.30, 32 bits), so entries pass through.
	function automatic logic [sje_pkg::OUT_WIDTH-1:0] solve_eigen(
		logic [sje_pkg::IN_WIDTH-1:0] mat);
		longint a[9];
		longint v[9];
		longint u;
		longint w;
		longint apq;
		longint c;
		longint s;
		int ord[3];
		int p;
		int q;
		int t;
		logic [sje_pkg::OUT_WIDTH-1:0] res;
		a[0] = longint'($signed(mat[0*32 +: 32]));
		a[1] = longint'($signed(mat[1*32 +: 32]));
		a[2] = longint'($signed(mat[2*32 +: 32]));
		a[4] = longint'($signed(mat[3*32 +: 32]));
		a[5] = longint'($signed(mat[4*32 +: 32]));
		a[8] = longint'($signed(mat[5*32 +: 32]));
		a[3] = a[1]; a[6] = a[2]; a[7] = a[5];
		for (int i = 0; i < 9; i++) v[i] = (i % 4 == 0) ? (64'sd1 <<< sje_pkg::FRAC_BITS) : 0;
		for (int i = 0; i < 9; i += 4) v[i] = sat_word(v[i]);
		for (int sw = 0; sw < sweeps_max; sw++) begin
			if (abs_u(a[1]) + abs_u(a[2]) + abs_u(a[5]) < conv_limit) break;
			for (int pr = 0; pr < 3; pr++) begin
				p = (pr == 2) ? 1 : 0;
				q = (pr == 0) ? 1 : 2;
				apq = a[p*3+q];
				if (abs_u(apq) < skip_limit) continue;
				cos_sin_of(half_theta(2 * apq, a[q*3+q] - a[p*3+p]), c, s);
				for (int k = 0; k < 3; k++) begin
					u = a[k*3+p]; w = a[k*3+q];
					a[k*3+p] = rotate_pair(c, u, -s, w);
					a[k*3+q] = rotate_pair(s, u, c, w);
				end
				for (int k = 0; k < 3; k++) begin
					u = a[p*3+k]; w = a[q*3+k];
					a[p*3+k] = rotate_pair(c, u, -s, w);
					a[q*3+k] = rotate_pair(s, u, c, w);
				end
				for (int k = 0; k < 3; k++) begin
					u = v[k*3+p]; w = v[k*3+q];
					v[k*3+p] = rotate_pair(c, u, -s, w);
					v[k*3+q] = rotate_pair(s, u, c, w);
				end
			end
		end
		ord = '{0, 1, 2};
		for (int i = 0; i < 2; i++)
			for (int j = i + 1; j < 3; j++)
				if (a[ord[j]*4] > a[ord[i]*4]) begin
					t = ord[i]; ord[i] = ord[j]; ord[j] = t;
				end
		res[0*32 +: 32] = a[ord[0]*4][31:0];
		res[1*32 +: 32] = a[ord[1]*4][31:0];
		for (int k = 0; k < 3; k++) begin
			res[(2+k)*32 +: 32] = v[k*3+ord[0]][31:0];
			res[(5+k)*32 +: 32] = v[k*3+ord[1]][31:0];
		end
		return res;
	endfunction

	// ---------------------------------------------------------------- clock, reset

	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
	end

	// ---------------------------------------------------------------- receiver

	// Random stalls, a calm stretch, and a long hold-off counted here on request
	int hold_seen;
	int hold_left;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			hold_seen     <= 0;
			hold_left     <= 0;
		end else if (hold_seen != hold_req_id) begin
			hold_seen     <= hold_req_id;
			hold_left     <= HOLD_CYCLES;
			m_axis_tready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left     <= hold_left - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	// Compare each result transaction with the oldest prediction
	always @(posedge clk) begin
		logic [sje_pkg::OUT_WIDTH-1:0] want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			results_seen++;
			if (eigen_queue.size() == 0) begin
				$error("result transaction with no prediction waiting: %h", m_axis_tdata);
				fail_count++;
			end else begin
				want = eigen_queue.pop_front();
				for (int f = 0; f < 8; f++)
					if (want[f*32 +: 32] !== m_axis_tdata[f*32 +: 32]) begin
						$error("%s: expected %0d, got %0d", field_name[f],
							$signed(want[f*32 +: 32]), $signed(m_axis_tdata[f*32 +: 32]));
						fail_count++;
					end
			end
		end
	end

	// Watchdog: end the run when no transaction moves for too long
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("timeout after %0d idle cycles", STALL_LIMIT);
			$display("symmetric_3x3_jacobi_eigen: mismatch");
			$finish;
		end
	end

	// ---------------------------------------------------------------- sender

	// Offer one matrix; valid stays high after acceptance until a gap drops it.
	task automatic send_matrix(input logic [sje_pkg::IN_WIDTH-1:0] mat);
		if (!calm && $urandom_range(99) < IDLE_PCT) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < IDLE_PCT) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= mat;
		do @(posedge clk); while (!s_axis_tready);
		eigen_queue.push_back(solve_eigen(mat));
		matrices_sent++;
	endtask

	task automatic send_entries(input logic [31:0] xx, xy, xz, yy, yz, zz);
		send_matrix({zz, yz, yy, xz, xy, xx});
	endtask

	// Drop valid and wait for every pending result
	task automatic drain;
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (eigen_queue.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// Write enable is left high; the caller drops it after the last write
	task automatic write_reg(input sje_pkg::cfg_idx_t idx,
		input logic [sje_pkg::CFG_DATA_W-1:0] val);
		cfg_wr_en <= 1'b1;
		cfg_addr  <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_writes++;
		case (idx)
			sje_pkg::CFG_SWEEP_LIMIT: sweeps_max = val[sje_pkg::SWEEP_W-1:0];
			sje_pkg::CFG_CONV_THR:    conv_limit = val;
			sje_pkg::CFG_SKIP_THR:    skip_limit = val;
			default: ;
		endcase
	endtask

	task automatic set_regs(input int sl, input int ct, input int st);
		drain();
		write_reg(sje_pkg::CFG_SWEEP_LIMIT, sje_pkg::CFG_DATA_W'(sl));
		write_reg(sje_pkg::CFG_CONV_THR, sje_pkg::CFG_DATA_W'(ct));
		write_reg(sje_pkg::CFG_SKIP_THR, sje_pkg::CFG_DATA_W'(st));
		cfg_wr_en <= 1'b0;
	endtask

	function automatic logic [31:0] corner_value();
		case ($urandom_range(5))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'h0000_0000;
			3: return 32'hFFFF_FFFF;
			4: return 32'h4000_0000;
			default: return 32'h0000_0001;
		endcase
	endfunction

	// Mix of full range, scaled down, nearly diagonal and corner matrices
	function automatic logic [sje_pkg::IN_WIDTH-1:0] random_matrix();
		logic [sje_pkg::IN_WIDTH-1:0] m;
		int sh;
		int kind;
		kind = $urandom_range(9);
		sh = $urandom_range(28);
		for (int f = 0; f < 6; f++) begin
			m[f*32 +: 32] = $urandom;
			if (kind >= 4 && kind <= 6) m[f*32 +: 32] = $signed(m[f*32 +: 32]) >>> sh;
			if (kind >= 7 && kind <= 8 && f != 0 && f != 3 && f != 5)
				m[f*32 +: 32] = $signed(m[f*32 +: 32]) >>> (12 + sh / 2);
			if (kind == 9) m[f*32 +: 32] = corner_value();
		end
		return m;
	endfunction

	// ---------------------------------------------------------------- tests

	task automatic test_directed;
		// reset values: 10 sweeps, both thresholds one
		send_entries(0, 0, 0, 0, 0, 0);
		send_entries(32'h4000_0000, 0, 0, 32'h4000_0000, 0, 32'h4000_0000);   // equal diagonal
		send_entries(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
			32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);                     // overflow
		send_entries(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		send_entries(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		send_entries(32'h1000_0000, 32'h0800_0000, 32'hF800_0000,
			32'h2000_0000, 32'h0400_0000, 32'hE000_0000);
		send_entries(32'hC000_0000, 32'h0000_0001, 0, 32'h4000_0000, 32'hFFFF_FFFF, 0);
		// zero thresholds: zero vector and negative difference with a zero entry
		set_regs(15, 0, 0);
		send_entries(32'h2000_0000, 0, 0, 32'h2000_0000, 0, 32'h2000_0000);
		send_entries(32'h3000_0000, 0, 0, 32'h1000_0000, 0, 32'hF000_0000);
		send_entries(32'h1234_5678, 32'h0765_4321, 32'hF00F_F00F,
			32'hE000_0001, 32'h0000_0003, 32'h3FFF_FFFF);
		// sweep limit zero: diagonal sorted as it came in
		set_regs(0, 1, 1);
		send_entries(32'h1000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h3000_0000, 0, 32'h2000_0000);
		send_entries(32'h1000_0000, 1, 1, 32'h1000_0000, 1, 32'h1000_0000);
		// largest thresholds: converged at once, then off-diagonals at or above the skip limit
		set_regs(15, 1048575, 1);
		send_entries(32'h1000_0000, 32'h0001_0000, 32'h0002_0000, 32'h2000_0000, 32'h0003_0000, 0);
		set_regs(1, 0, 1048575);
		send_entries(32'h1000_0000, 32'h0001_0000, 32'h4000_0000, 32'h2000_0000, 32'h0003_0000, 0);
		send_entries(32'h1000_0000, 32'hFFF0_0001, 32'h000F_FFFF, 32'h2000_0000, 32'h0010_0000, 0);
	endtask

	// Receiver holds off while the sender keeps offering, so the input stalls
	task automatic test_backpressure;
		set_regs(2, 1, 1);
		hold_req_id++;
		for (int i = 0; i < 6; i++) send_matrix(random_matrix());
	endtask

	task automatic test_random;
		int sl;
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 100 == 0) begin
				sl = ($urandom_range(9) == 0) ? $urandom_range(1) * 15 : $urandom_range(1, 15);
				set_regs(sl,
					($urandom_range(4) == 0) ? $urandom_range(1048575) : $urandom_range(16),
					($urandom_range(4) == 0) ? $urandom_range(1048575) : $urandom_range(16));
			end
			calm = (n >= 500 && n < 600);
			send_matrix(random_matrix());
		end
		calm = 1'b0;
	endtask

	initial begin
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		cfg_wr_en     = 1'b0;
		cfg_addr      = sje_pkg::CFG_SWEEP_LIMIT;
		cfg_wdata     = '0;
		calm          = 1'b0;
		hold_req_id   = 0;
		stall_cycles  = 0;
		fail_count    = 0;
		matrices_sent = 0;
		results_seen  = 0;
		cfg_writes    = 0;
		sweeps_max    = 10;
		conv_limit    = 1;
		skip_limit    = 1;
		atan_q60[0] = atan_sum(64'd1 << 59, 4, 0) + atan_sum((64'd1 << 60) / 3, 9, 0);
		for (int i = 1; i < sje_pkg::CORDIC_STEPS; i++)
			atan_q60[i] = atan_sum((64'd1 << 60) >> i, 1, 2 * i);
		pi_q60 = 4 * atan_q60[0];

		@(posedge arst_n);
		@(posedge clk);
		test_directed();
		test_backpressure();
		test_random();
		drain();
		repeat (50) @(posedge clk);

		$display("covered %0d matrices, %0d results, %0d register writes",
			matrices_sent, results_seen, cfg_writes);
		$display("sweep limits 0..15, thresholds 0..max, long output hold-off and stall gaps");
		if (fail_count == 0 && eigen_queue.size() == 0) begin
			$display("symmetric_3x3_jacobi_eigen: match");
		end else begin
			if (eigen_queue.size() != 0)
				$error("%0d predicted results never arrived", eigen_queue.size());
			$display("symmetric_3x3_jacobi_eigen: mismatch");
		end
		$finish;
	end

endmodule
